// File: hw/rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types, constants and the PWM duty function for the pendant frame
// parser.
// ----------------------------------------------------------------------------
package pfp_pkg;

  // Character that opens a frame when it arrives with the marker bit set
  localparam logic [7:0] FRAME_START = 8'hFF;
  // A valid switch byte has its low nibble equal to the complement of its high nibble
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // Duty = DUTY_OFFSET + (level * DUTY_GAIN) >> DUTY_SHIFT, and 0 for level 0
  localparam logic [9:0]  DUTY_OFFSET = 10'd35;
  localparam logic [13:0] DUTY_GAIN   = 14'd62;
  localparam int unsigned DUTY_SHIFT  = 4;

  // Switch nibble bit positions
  localparam int unsigned SW_FWD_BIT  = 1;
  localparam int unsigned SW_REV_BIT  = 2;
  localparam int unsigned SW_COOL_BIT = 3;

  // Fields of one result item
  typedef struct packed {
    logic       frame_accepted;
    logic [3:0] switch_nibble;
    logic [7:0] level_value;
    logic       spindle_forward;
    logic       spindle_reverse;
    logic       coolant_on;
    logic [9:0] pwm_duty;
  } result_t;

  // PWM duty from the level: one 8x6 constant multiply, a shift and an add
  function automatic logic [9:0] duty_of(input logic [7:0] level);
    logic [13:0] prod;
    logic [9:0]  duty;
    prod = 14'(level) * DUTY_GAIN;
    if (level == 8'd0) begin
      duty = 10'd0;
    end else begin
      duty = DUTY_OFFSET + 10'(prod >> DUTY_SHIFT);
    end
    return duty;
  endfunction

endpackage

// File: hw/rtl/pfp_decoder.sv
// ----------------------------------------------------------------------------
// pfp_decoder
// Frame position tracker and held switch/level/duty registers. Takes one
// character per step and gives the result item that the step produces.
// ----------------------------------------------------------------------------
module pfp_decoder
  import pfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,        // advance state on the presented character
  input  logic [7:0] rx_byte,
  input  logic       marker_bit,
  output result_t    result       // outputs after this character
);

  typedef enum logic [2:0] {
    POS_IDLE      = 3'd0,
    POS_SWITCH    = 3'd1,
    POS_SWITCH_N  = 3'd2,
    POS_LEVEL     = 3'd3,
    POS_LEVEL_N   = 3'd4,
    POS_DONE      = 3'd5
  } pos_t;

  pos_t       pos_r, pos_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [3:0] held_sw_r, held_sw_nxt;
  logic [7:0] held_level_r, held_level_nxt;
  logic [9:0] held_duty_r, held_duty_nxt;
  logic       accepted;
  logic       nibble_ok;

  // Switch byte check: low nibble must be the complement of the high nibble
  assign nibble_ok = ((first_r[3:0] ^ first_r[7:4]) == NIBBLE_MASK);

  // Next-state logic for one character
  always_comb begin
    pos_nxt        = pos_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    held_sw_nxt    = held_sw_r;
    held_level_nxt = held_level_r;
    held_duty_nxt  = held_duty_r;
    accepted       = 1'b0;
    if (step) begin
      if (marker_bit) begin
        // only a marked start character matters; other marked bytes are ignored
        if (rx_byte == FRAME_START) begin
          pos_nxt = POS_SWITCH;
        end
      end else begin
        unique case (pos_r)
          POS_SWITCH: begin
            first_nxt = rx_byte;
            pos_nxt   = POS_SWITCH_N;
          end
          POS_SWITCH_N: begin
            pos_nxt = (first_r == ~rx_byte) ? POS_LEVEL : POS_IDLE;
          end
          POS_LEVEL: begin
            second_nxt = rx_byte;
            pos_nxt    = POS_LEVEL_N;
          end
          POS_LEVEL_N: begin
            if (second_r != ~rx_byte) begin
              pos_nxt = POS_IDLE;
            end else begin
              pos_nxt = POS_DONE;
              if (nibble_ok) begin
                held_level_nxt = second_r;
                held_duty_nxt  = duty_of(second_r);
                held_sw_nxt    = first_r[7:4];
                accepted       = 1'b1;
              end
            end
          end
          default: begin
            pos_nxt = POS_IDLE;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_IDLE;
      first_r      <= 8'd0;
      second_r     <= 8'd0;
      held_sw_r    <= 4'd0;
      held_level_r <= 8'd0;
      held_duty_r  <= 10'd0;
    end else begin
      pos_r        <= pos_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      held_sw_r    <= held_sw_nxt;
      held_level_r <= held_level_nxt;
      held_duty_r  <= held_duty_nxt;
    end
  end

  // Result reflects the held values after this character
  always_comb begin
    result.frame_accepted  = accepted;
    result.switch_nibble   = held_sw_nxt;
    result.level_value     = held_level_nxt;
    result.spindle_forward = held_sw_nxt[SW_FWD_BIT];
    result.spindle_reverse = held_sw_nxt[SW_REV_BIT];
    result.coolant_on      = held_sw_nxt[SW_COOL_BIT];
    result.pwm_duty        = held_duty_nxt;
  end

  // Assertions
  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && marker_bit && (rx_byte == FRAME_START) |=> pos_r == POS_SWITCH)
    else $error("start character did not restart the frame");

  a_accept_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    accepted |-> step && !marker_bit && (pos_r == POS_LEVEL_N) && nibble_ok)
    else $error("frame accepted outside the final payload byte");

  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !accepted |=> $stable(held_sw_r) && $stable(held_level_r) && $stable(held_duty_r))
    else $error("held outputs changed without an accepted frame");

  a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    accepted |=> pos_r == POS_DONE)
    else $error("accepted frame did not end in the done position");

endmodule

// File: hw/rtl/pendant_frame_parser_core.sv
// ----------------------------------------------------------------------------
// pendant_frame_parser_core
// Hand-pendant frame parser: 9-bit characters in, held switch, level and
// PWM duty outputs out, one result item per character.
// ----------------------------------------------------------------------------
// Every accepted character yields exactly one result item. The block takes one
// character per clock cycle while the sink keeps up. Each character passes
// through the input register and then the result register, with the frame
// decode and the duty multiply between them. A result waiting on out_tready
// stalls the input only when both registers are full, so throughput is one
// item per cycle while the sink keeps up.
module pendant_frame_parser_core
  import pfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] marker_bit
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] switch_nibble, [11:4] level_value,
                                  // [12] spindle_forward, [13] spindle_reverse,
                                  // [14] coolant_on, [24:15] pwm_duty, [31:25] 0
  output logic        out_tuser   // [0] frame_accepted
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_marker_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    dec_res;
  logic       out_free;
  logic       step;

  // Handshake: result register free when empty or being drained
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r   <= in_tdata;
      in_marker_r <= in_tuser;
    end
  end

  // Frame decode and held state
  pfp_decoder u_decoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (in_byte_r),
    .marker_bit (in_marker_r),
    .result     (dec_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= dec_res;
    end
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.frame_accepted;
  assign out_tdata  = {7'd0,
                       out_res_r.pwm_duty,
                       out_res_r.coolant_on,
                       out_res_r.spindle_reverse,
                       out_res_r.spindle_forward,
                       out_res_r.level_value,
                       out_res_r.switch_nibble};

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pendant frame parser. Characters are driven as
// short directed sequences, then as mostly well-formed random frames mixed
// with broken frames and line noise. A tracker predicts the held switch,
// level and duty outputs for every accepted item, and each result item is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import pfp_pkg::*;
();

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int DIRECTED_MAX  = 25;
  localparam int PHASE_ITEMS   = 510;
  localparam int REPORT_LIMIT  = 10;

  // Ways a random frame may be spoilt
  typedef enum int {
    FLAW_NONE,
    FLAW_SWITCH_COMPL,
    FLAW_LEVEL_COMPL,
    FLAW_RESTART,
    FLAW_STRAY_MARK
  } frame_flaw_t;

  // --------------------------------------------------------------------------
  // Tracks the frame decoder and holds the result items still owed
  // --------------------------------------------------------------------------
  class pendant_tracker;
    typedef enum logic [2:0] {
      POS_IDLE,
      POS_SWITCH,
      POS_SWITCH_INV,
      POS_LEVEL,
      POS_LEVEL_INV,
      POS_DONE
    } frame_pos_t;

    frame_pos_t pos;
    logic [7:0] switch_byte;
    logic [7:0] level_byte;
    logic [3:0] held_sw;
    logic [7:0] held_lvl;
    logic [9:0] held_pwm;
    result_t    due_reports[$];
    int         errors;

    function new();
      pos         = POS_IDLE;
      switch_byte = '0;
      level_byte  = '0;
      held_sw     = '0;
      held_lvl    = '0;
      held_pwm    = '0;
      errors      = 0;
    endfunction

    // 35 + level*62/16, forced to zero at level zero
    function logic [9:0] pwm_for(input logic [7:0] lvl);
      int scaled;
      scaled = 35 + (int'(lvl) * 62) / 16;
      if (lvl == 8'd0) begin
        scaled = 0;
      end
      return scaled[9:0];
    endfunction

    // Advance the decoder by one accepted character and queue its report
    function void take_char(input logic [7:0] data, input logic marker);
      result_t due;
      logic    latched;
      latched = 1'b0;
      if (marker) begin
        if (data == FRAME_START) begin
          pos = POS_SWITCH;
        end
      end else begin
        case (pos)
          POS_SWITCH: begin
            switch_byte = data;
            pos = POS_SWITCH_INV;
          end
          POS_SWITCH_INV: begin
            if (switch_byte == ~data) begin
              pos = POS_LEVEL;
            end else begin
              pos = POS_IDLE;
            end
          end
          POS_LEVEL: begin
            level_byte = data;
            pos = POS_LEVEL_INV;
          end
          POS_LEVEL_INV: begin
            if (level_byte != ~data) begin
              pos = POS_IDLE;
            end else begin
              pos = POS_DONE;
              if ((switch_byte[7:4] ^ switch_byte[3:0]) == 4'hF) begin
                held_sw  = switch_byte[7:4];
                held_lvl = level_byte;
                held_pwm = pwm_for(level_byte);
                latched  = 1'b1;
              end
            end
          end
          default: begin
            pos = POS_IDLE;
          end
        endcase
      end
      due.frame_accepted  = latched;
      due.switch_nibble   = held_sw;
      due.level_value     = held_lvl;
      due.spindle_forward = held_sw[1];
      due.spindle_reverse = held_sw[2];
      due.coolant_on      = held_sw[3];
      due.pwm_duty        = held_pwm;
      due_reports.push_back(due);
    endfunction

    // Compare one accepted result item with the oldest report owed
    function void match_report(input logic [31:0] data, input logic flag);
      result_t got;
      result_t due;
      got.frame_accepted  = flag;
      got.switch_nibble   = data[3:0];
      got.level_value     = data[11:4];
      got.spindle_forward = data[12];
      got.spindle_reverse = data[13];
      got.coolant_on      = data[14];
      got.pwm_duty        = data[24:15];
      if (due_reports.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("ERROR: result item with nothing owed, tdata=%h tuser=%b", data, flag);
        end
        return;
      end
      due = due_reports.pop_front();
      if (got !== due) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("ERROR: expected acc=%b sw=%h lvl=%h fwd=%b rev=%b cool=%b duty=%0d",
                   due.frame_accepted, due.switch_nibble, due.level_value,
                   due.spindle_forward, due.spindle_reverse, due.coolant_on, due.pwm_duty);
          $display("       actual   acc=%b sw=%h lvl=%h fwd=%b rev=%b cool=%b duty=%0d",
                   got.frame_accepted, got.switch_nibble, got.level_value,
                   got.spindle_forward, got.spindle_reverse, got.coolant_on, got.pwm_duty);
        end
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  pendant_tracker tracker;
  int tx_idle_pct = 7;
  int rx_idle_pct = 67;
  int chars_sent  = 0;
  int stall_count = 0;

  pendant_frame_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // Sink back-pressure
  always @(negedge clk) begin
    out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  // Handshake monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        tracker.take_char(in_tdata, in_tuser);
      end
      if (out_tvalid && out_tready) begin
        tracker.match_report(out_tdata, out_tuser);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_count <= 0;
    end else if (stall_count + 1 >= STALL_LIMIT) begin
      $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Drive one character; called and returns at a falling edge
  task automatic send_char(input logic [7:0] data, input logic marker);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= marker;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  // Start character, switch byte and level byte, each with its complement
  task automatic send_frame(input logic [3:0] sw, input logic [7:0] lvl,
                            input logic nibble_ok, input frame_flaw_t flaw);
    logic [7:0] sw_byte;
    logic [7:0] sw_compl;
    logic [7:0] lvl_compl;
    sw_byte = {sw, ~sw};
    if (!nibble_ok) begin
      sw_byte[3:0] = sw_byte[3:0] ^ 4'($urandom_range(15, 1));
    end
    sw_compl  = ~sw_byte;
    lvl_compl = ~lvl;
    if (flaw == FLAW_SWITCH_COMPL) begin
      sw_compl = sw_compl ^ 8'($urandom_range(255, 1));
    end
    if (flaw == FLAW_LEVEL_COMPL) begin
      lvl_compl = lvl_compl ^ 8'($urandom_range(255, 1));
    end
    send_char(FRAME_START, 1'b1);
    send_char(sw_byte, 1'b0);
    // a marked character other than the start leaves the frame running
    if (flaw == FLAW_STRAY_MARK) begin
      send_char(8'($urandom_range(254)), 1'b1);
    end
    send_char(sw_compl, 1'b0);
    send_char(lvl, 1'b0);
    // start character mid-frame, then a complete frame after it
    if (flaw == FLAW_RESTART) begin
      send_char(FRAME_START, 1'b1);
      send_char(sw_byte, 1'b0);
      send_char(~sw_byte, 1'b0);
      send_char(lvl, 1'b0);
    end
    send_char(lvl_compl, 1'b0);
  endtask

  // Mostly sound frames, some spoilt, the rest noise
  task automatic random_traffic(input int goal);
    int         pick;
    logic [7:0] lvl;
    while (chars_sent < goal) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0:       lvl = 8'h00;
        1:       lvl = 8'hFF;
        2:       lvl = 8'h01;
        default: lvl = 8'($urandom_range(255));
      endcase
      if (pick < 70) begin
        send_frame(4'($urandom_range(15)), lvl, $urandom_range(9) != 0, FLAW_NONE);
      end else if (pick < 85) begin
        send_frame(4'($urandom_range(15)), lvl, $urandom_range(9) != 0,
                   frame_flaw_t'($urandom_range(FLAW_STRAY_MARK, FLAW_SWITCH_COMPL)));
      end else if (pick < 90) begin
        send_char(FRAME_START, 1'b1);
      end else begin
        send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle noise, extremes of level and switches, failed nibble check,
    // unmarked byte after a finished frame, start character repeated
    send_char(8'h00, 1'b0);
    send_char(8'h7F, 1'b1);
    send_frame(4'hF, 8'hFF, 1'b1, FLAW_NONE);
    send_char(8'hFF, 1'b0);
    send_frame(4'h0, 8'h00, 1'b1, FLAW_NONE);
    send_frame(4'h6, 8'h80, 1'b0, FLAW_NONE);
    send_frame(4'hA, 8'h01, 1'b1, FLAW_NONE);
    send_char(FRAME_START, 1'b1);
    send_char(FRAME_START, 1'b1);

    // Random: sender rarely idle, then sink rarely idle, then no idling
    random_traffic(DIRECTED_MAX + PHASE_ITEMS);
    tx_idle_pct = 67;
    rx_idle_pct = 7;
    random_traffic(DIRECTED_MAX + 2 * PHASE_ITEMS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_traffic(DIRECTED_MAX + 3 * PHASE_ITEMS);
    in_tvalid <= 1'b0;

    // Drain, then allow for any stray result items
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.due_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
